// ===== sv/sha256_pkg.sv =====
// SHA-256 hasher package: types, constants and round functions.
package sha256_pkg;

   localparam logic [31:0] H_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] K_ROUND [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] PAD_MARK = 32'h80000000;

   typedef struct packed {
      logic [31:0] message_word;
      logic [2:0]  valid_bytes;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        digest_last;
   } rsp_type;

   // word source for the block buffer
   typedef enum logic [2:0] {
      SRC_DATA = 3'b000,
      SRC_ZERO = 3'b001,
      SRC_LEN_HI = 3'b010,
      SRC_LEN_LO = 3'b011,
      SRC_MARK = 3'b100
   } src_type;

   typedef struct packed {
      logic    put;        // write a word into the block buffer
      src_type src;
      logic    take_input; // latch the request word, update length
      logic    round_start;
      logic    round_step;
      logic    fold;       // add working vars into chain value
      logic    chain_init;
      logic    out_load;   // load digest word at out index
      logic    out_next;
   } cmd_type;

   typedef struct packed {
      logic [3:0] fill;
      logic       round_done;
      logic       short_word; // last word with under four bytes
      logic [2:0] out_index;
   } sts_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// ===== sv/sha256_if.sv =====
// Valid/ready channel interface.
interface sha256_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sha256_datapath.sv =====
// SHA-256 datapath: block buffer, schedule, round unit, chain value, output register.
module sha256_datapath import sha256_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  req_type     req_data,
   output sts_type     sts,
   output rsp_type     rsp_data
);
   logic [31:0] w_ff [16];
   logic [31:0] w_in;
   logic [3:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [31:0] word_ff;
   logic [2:0]  nb_ff;
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [5:0]  rnd_ff;
   logic        rdone_ff;
   logic [2:0]  oidx_ff;
   rsp_type     rsp_ff;
   logic [2:0]  nb;
   logic [31:0] keep, masked, wt, wnew, t1, t2, e, a;

   assign nb = (req_data.valid_bytes > 3'd4) ? 3'd4 : req_data.valid_bytes;

   always_comb begin
      keep = 32'hffffffff << (6'd32 - {nb_ff, 3'b000});
      if (nb_ff == 3'd0) keep = '0;
      masked = (word_ff & keep) | (32'h00000080 << (5'd24 - {nb_ff[1:0], 3'b000}));
      if (nb_ff == 3'd4) masked = word_ff;
      unique case (cmd.src)
         SRC_DATA:   w_in = masked;
         SRC_ZERO:   w_in = '0;
         SRC_LEN_HI: w_in = bits_ff[63:32];
         SRC_LEN_LO: w_in = bits_ff[31:0];
         SRC_MARK:   w_in = PAD_MARK;
         default:    w_in = '0;
      endcase
   end

   assign wt = w_ff[0];
   assign wnew = sig1(w_ff[14]) + w_ff[9] + sig0(w_ff[1]) + w_ff[0];
   assign e = v_ff[4];
   assign a = v_ff[0];
   assign t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
             + ((e & v_ff[5]) ^ (~e & v_ff[6])) + K_ROUND[rnd_ff] + wt;
   assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
             + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_ff @(posedge clock) begin
      if (cmd.take_input) begin
         word_ff <= req_data.message_word;
         nb_ff   <= req_data.last_word ? nb : 3'd4;
      end
      if (cmd.put) w_ff[fill_ff] <= w_in;
      if (cmd.round_step) begin
         // schedule window slides one word per round
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= wnew;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end else if (cmd.round_start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end
      if (cmd.out_load) begin
         rsp_ff.digest_word <= h_ff[oidx_ff];
         rsp_ff.word_index  <= oidx_ff;
         rsp_ff.digest_last <= (oidx_ff == 3'd7);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         bits_ff  <= '0;
         rnd_ff   <= '0;
         rdone_ff <= 1'b0;
         oidx_ff  <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= H_INIT[i];
      end else begin
         if (cmd.take_input)
            bits_ff <= bits_ff + {58'd0, (req_data.last_word ? nb : 3'd4), 3'b000};
         if (cmd.put) fill_ff <= fill_ff + 4'd1;
         if (cmd.round_start) begin
            rnd_ff <= '0;
            rdone_ff <= 1'b0;
         end else if (cmd.round_step) begin
            rnd_ff <= rnd_ff + 6'd1;
            rdone_ff <= (rnd_ff == 6'd63);
         end
         if (cmd.fold)
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         if (cmd.chain_init) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= H_INIT[i];
            bits_ff <= '0;
            fill_ff <= '0;
         end
         if (cmd.out_next) oidx_ff <= oidx_ff + 3'd1;
      end
   end

   assign sts.fill = fill_ff;
   assign sts.round_done = rdone_ff;
   assign sts.short_word = (nb_ff != 3'd4);
   assign sts.out_index = oidx_ff;
   assign rsp_data = rsp_ff;

   property p_fold_after_rounds;
      @(posedge clock) disable iff (reset) cmd.fold |-> rdone_ff;
   endproperty
   a_fold_after_rounds: assert property (p_fold_after_rounds)
      else $error("fold before 64 rounds");

   a_no_put_in_rounds: assert property (@(posedge clock) disable iff (reset)
      cmd.round_step |-> !cmd.put) else $error("buffer write during rounds");

   a_round_count: assert property (@(posedge clock) disable iff (reset)
      cmd.round_step && rnd_ff == 6'd63 |=> rdone_ff) else $error("round count slip");
endmodule

// ===== sv/sha256_control.sv =====
// SHA-256 controller state machine.
module sha256_control import sha256_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_PUT   = 8'b00000010,
      S_MARK  = 8'b00000100,
      S_PAD   = 8'b00001000,
      S_LEN   = 8'b00010000,
      S_ROUND = 8'b00100000,
      S_FOLD  = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic last_ff, last_in;
   logic lenlo_ff, lenlo_in;
   logic fin_ff, fin_in;   // compressing a block that ends the message
   logic ov_ff, ov_in;     // output register holds a word
   // marker placed already for this message
   logic mark_done_ff, mark_done_in;
   logic full;

   assign full = (sts.fill == 4'd15);

   always_comb begin
      cmd = '0;
      cmd.src = SRC_DATA;
      state_in = state_ff;
      last_in = last_ff;
      lenlo_in = lenlo_ff;
      fin_in = fin_ff;
      ov_in = ov_ff;
      req_ready = 1'b0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_input = 1'b1;
               last_in = req_data.last_word;
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            cmd.put = 1'b1;
            cmd.src = SRC_DATA;
            if (full) begin
               cmd.round_start = 1'b1;
               state_in = S_ROUND;
            end else if (last_ff) state_in = sts.short_word ? S_PAD : S_MARK;
            else state_in = S_IDLE;
         end
         S_MARK: begin
            cmd.put = 1'b1;
            cmd.src = SRC_MARK;
            if (full) begin
               cmd.round_start = 1'b1;
               state_in = S_ROUND;
            end else state_in = S_PAD;
         end
         S_PAD: begin
            // pad to word 14, or through the end when no room for length
            if (sts.fill == 4'd14) state_in = S_LEN;
            else begin
               cmd.put = 1'b1;
               cmd.src = SRC_ZERO;
               if (full) begin
                  cmd.round_start = 1'b1;
                  state_in = S_ROUND;
               end
            end
         end
         S_LEN: begin
            cmd.put = 1'b1;
            cmd.src = lenlo_ff ? SRC_LEN_LO : SRC_LEN_HI;
            lenlo_in = !lenlo_ff;
            if (lenlo_ff) begin
               fin_in = 1'b1;
               cmd.round_start = 1'b1;
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            if (sts.round_done) state_in = S_FOLD;
            else cmd.round_step = 1'b1;
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            if (fin_ff) state_in = S_OUT;
            else if (!last_ff) state_in = S_IDLE;
            else if (lenlo_ff || sts.fill != 4'd0) state_in = S_PAD;
            else state_in = S_PAD;
            // a full last word that completed the block still needs the marker
            if (!fin_ff && last_ff && !sts.short_word && !mark_done_ff) state_in = S_MARK;
         end
         S_OUT: begin
            if (!ov_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               cmd.out_next = 1'b1;
               ov_in = 1'b1;
               if (sts.out_index == 3'd7) begin
                  cmd.chain_init = 1'b1;
                  fin_in = 1'b0;
                  last_in = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mark_done_in = mark_done_ff;
      if (state_ff == S_PUT && last_ff && sts.short_word) mark_done_in = 1'b1;
      if (state_ff == S_MARK) mark_done_in = 1'b1;
      if (cmd.chain_init) mark_done_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff <= 1'b0;
         lenlo_ff <= 1'b0;
         fin_ff <= 1'b0;
         ov_ff <= 1'b0;
         mark_done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
         lenlo_ff <= lenlo_in;
         fin_ff <= fin_in;
         ov_ff <= ov_in;
         mark_done_ff <= mark_done_in;
      end
   end

   assign rsp_valid = ov_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!ov_ff || rsp_ready)) else $error("output overwritten");
   a_len_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LEN && !lenlo_ff |=> state_ff == S_LEN) else $error("length split");
endmodule

// ===== sv/sha256_message_hasher.sv =====
// SHA-256 message hasher top level.
// Takes one message word per transaction and hashes it with one compression round per
// clock. Each word is written into the 16-word block buffer before the next is taken;
// the word that completes a block starts the rounds and fold in the shared round unit,
// and no new word is taken until they finish. The last word adds padding writes and one
// or two compressions, then the eight digest words leave in order, one per cycle when
// the sink is ready, and the chain value returns to the initial hash for the next message.
module sha256_message_hasher import sha256_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   sha256_if.sink   req,
   sha256_if.source rsp
);
   cmd_type cmd;
   sts_type sts;

   sha256_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_data(req.data), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts(sts), .cmd(cmd)
   );

   sha256_datapath u_datapath (
      .clock(clock), .reset(reset),
      .cmd(cmd), .req_data(req.data), .sts(sts), .rsp_data(rsp.data)
   );
endmodule
